>>> hdl/sha1md_pkg.sv
`timescale 1ns / 1ps

package sha1md_pkg;

   localparam int unsigned BLOCK_WORDS = 16;
   localparam int unsigned CHAIN_WORDS = 5;
   localparam logic [6:0]  LAST_ROUND  = 7'd79;
   localparam logic [5:0]  LAST_SLOT   = 6'd63;
   localparam logic [5:0]  LEN_SLOT    = 6'd56;
   localparam logic [7:0]  PAD_MARK    = 8'h80;

   typedef logic [31:0] word_type;
   typedef word_type [CHAIN_WORDS-1:0] chain_type;

   // One incoming message word: a byte, its valid flag and the end flag.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word_0;
      logic [31:0] digest_word_1;
      logic [31:0] digest_word_2;
      logic [31:0] digest_word_3;
      logic [31:0] digest_word_4;
   } rsp_type;

   // Commands from the byte sequencer to the compression unit.
   typedef struct packed {
      logic        start;
      logic        restart;
      logic        wr_en;
      logic [3:0]  wr_addr;
      logic [31:0] wr_data;
   } comp_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PAD,
      ST_COMP,
      ST_EMIT
   } seq_state_type;

   typedef enum logic [1:0] {
      CS_IDLE,
      CS_LOAD,
      CS_ROUND,
      CS_ADD
   } comp_state_type;

   function automatic word_type init_word(input logic [2:0] idx);
      word_type w;
      unique case (idx)
         3'd0:    w = 32'h67452301;
         3'd1:    w = 32'hEFCDAB89;
         3'd2:    w = 32'h98BADCFE;
         3'd3:    w = 32'h10325476;
         3'd4:    w = 32'hC3D2E1F0;
         default: w = '0;
      endcase
      return w;
   endfunction

   function automatic word_type round_const(input logic [1:0] grp);
      word_type k;
      unique case (grp)
         2'd0:    k = 32'h5A827999;
         2'd1:    k = 32'h6ED9EBA1;
         2'd2:    k = 32'h8F1BBCDC;
         default: k = 32'hCA62C1D6;
      endcase
      return k;
   endfunction

   function automatic logic [1:0] round_group(input logic [6:0] t);
      logic [1:0] g;
      if (t < 7'd20) begin
         g = 2'd0;
      end else if (t < 7'd40) begin
         g = 2'd1;
      end else if (t < 7'd60) begin
         g = 2'd2;
      end else begin
         g = 2'd3;
      end
      return g;
   endfunction

endpackage

>>> hdl/sha1md_compress.sv
`timescale 1ns / 1ps

// Block memory plus the 80-round compression. The sequencer writes the
// sixteen block words into the memory; start runs one compression and
// done pulses in the cycle the chain value takes its update.
module sha1md_compress (
   input  logic                      clock,
   input  logic                      reset,
   input  sha1md_pkg::comp_ctrl_type ctrl,
   output logic                      done,
   output sha1md_pkg::chain_type     chain
);

   logic [31:0] block_mem [sha1md_pkg::BLOCK_WORDS];
   logic [3:0]  rd_addr;
   logic [31:0] rd_data_ff;

   sha1md_pkg::comp_state_type cs_ff, cs_in;
   logic [6:0]                 round_ff;
   sha1md_pkg::chain_type      regs_ff;
   sha1md_pkg::chain_type      chain_ff;
   sha1md_pkg::word_type       sched_ff [sha1md_pkg::BLOCK_WORDS];

   sha1md_pkg::word_type w_t, f_t, k_t, tmp_t, expand;
   logic [1:0]           grp;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         block_mem[ctrl.wr_addr] <= ctrl.wr_data;
      end
      rd_data_ff <= block_mem[rd_addr];
   end

   // The word for round t+1 is fetched during round t.
   assign rd_addr = (cs_ff == sha1md_pkg::CS_ROUND) ? round_ff[3:0] + 4'd1 : 4'd0;

   always_comb begin
      expand = sched_ff[13] ^ sched_ff[8] ^ sched_ff[2] ^ sched_ff[0];
      w_t    = (round_ff < 7'd16) ? rd_data_ff : {expand[30:0], expand[31]};
      grp    = sha1md_pkg::round_group(round_ff);
      k_t    = sha1md_pkg::round_const(grp);
      case (grp)
         2'd0:    f_t = (regs_ff[1] & regs_ff[2]) | (~regs_ff[1] & regs_ff[3]);
         2'd2:    f_t = (regs_ff[1] & regs_ff[2]) | (regs_ff[1] & regs_ff[3])
                        | (regs_ff[2] & regs_ff[3]);
         default: f_t = regs_ff[1] ^ regs_ff[2] ^ regs_ff[3];
      endcase
      tmp_t = {regs_ff[0][26:0], regs_ff[0][31:27]} + f_t + regs_ff[4] + k_t + w_t;
   end

   always_comb begin
      cs_in = cs_ff;
      done  = 1'b0;
      unique case (cs_ff)
         sha1md_pkg::CS_IDLE: begin
            if (ctrl.start) begin
               cs_in = sha1md_pkg::CS_LOAD;
            end
         end
         sha1md_pkg::CS_LOAD: begin
            cs_in = sha1md_pkg::CS_ROUND;
         end
         sha1md_pkg::CS_ROUND: begin
            if (round_ff == sha1md_pkg::LAST_ROUND) begin
               cs_in = sha1md_pkg::CS_ADD;
            end
         end
         sha1md_pkg::CS_ADD: begin
            done  = 1'b1;
            cs_in = sha1md_pkg::CS_IDLE;
         end
         default: cs_in = sha1md_pkg::CS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cs_ff <= sha1md_pkg::CS_IDLE;
      end else begin
         cs_ff <= cs_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         round_ff <= '0;
      end else if (cs_ff == sha1md_pkg::CS_ROUND) begin
         round_ff <= (round_ff == sha1md_pkg::LAST_ROUND) ? 7'd0 : round_ff + 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cs_ff == sha1md_pkg::CS_LOAD) begin
         regs_ff <= chain_ff;
      end else if (cs_ff == sha1md_pkg::CS_ROUND) begin
         regs_ff[4] <= regs_ff[3];
         regs_ff[3] <= regs_ff[2];
         regs_ff[2] <= {regs_ff[1][1:0], regs_ff[1][31:2]};
         regs_ff[1] <= regs_ff[0];
         regs_ff[0] <= tmp_t;
         for (int i = 0; i < sha1md_pkg::BLOCK_WORDS - 1; i++) begin
            sched_ff[i] <= sched_ff[i+1];
         end
         sched_ff[sha1md_pkg::BLOCK_WORDS-1] <= w_t;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.restart) begin
         for (int i = 0; i < sha1md_pkg::CHAIN_WORDS; i++) begin
            chain_ff[i] <= sha1md_pkg::init_word(3'(i));
         end
      end else if (cs_ff == sha1md_pkg::CS_ADD) begin
         for (int i = 0; i < sha1md_pkg::CHAIN_WORDS; i++) begin
            chain_ff[i] <= chain_ff[i] + regs_ff[i];
         end
      end
   end

   assign chain = chain_ff;

endmodule

>>> hdl/sha1_message_digest.sv
`timescale 1ns / 1ps

// Channel   Ports                              Direction  Moves
// request   req_valid req_stall req_data       in         one message byte and flags
// response  rsp_valid rsp_stall rsp_data       out        the 160-bit digest
//
// A word carrying a byte is taken one per cycle while req_stall is low.
// Every 64th byte starts a compression (one load, 80 rounds, one chain
// update) during which req_stall is high. The end of a message brings
// pad bytes (up to 72), placed one per cycle, and one or two
// compressions; the digest register is then loaded once it is free.
// Reset is synchronous and returns the chain to the initial values.
// A waiting digest does not block new input; only the next digest waits.
module sha1_message_digest (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  sha1md_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output sha1md_pkg::rsp_type rsp_data
);

   sha1md_pkg::seq_state_type state_ff, state_in;

   // Byte slot in the current block, and the bytes of a partial word.
   logic [5:0]  pos_ff, pos_in;
   logic [23:0] word_ff, word_in;
   logic [63:0] count_ff, count_in;

   // Padding progress: the 0x80 mark is placed, the length field has
   // begun, and the message is ending.
   logic mark_ff, mark_in;
   logic len_ff, len_in;
   logic fin_ff, fin_in;

   sha1md_pkg::rsp_type rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                      req_take;
   logic                      place;
   logic [7:0]                place_byte;
   logic [7:0]                len_byte;
   logic                      block_full;
   logic                      rsp_free;
   logic                      emit;
   sha1md_pkg::comp_ctrl_type ctrl;
   logic                      comp_done;
   sha1md_pkg::chain_type     chain;

   sha1md_compress u_compress (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .done  (comp_done),
      .chain (chain)
   );

   assign req_stall = (state_ff != sha1md_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // Length bytes go out most significant first at slots 56 to 63.
   assign len_byte = count_ff[{3'd7 - pos_ff[2:0], 3'b000} +: 8];

   always_comb begin
      place      = 1'b0;
      place_byte = req_data.data_byte;
      if (state_ff == sha1md_pkg::ST_IDLE) begin
         place = req_take && req_data.byte_valid;
      end else if (state_ff == sha1md_pkg::ST_PAD) begin
         place = 1'b1;
         if (!mark_ff) begin
            place_byte = sha1md_pkg::PAD_MARK;
         end else if (len_ff) begin
            place_byte = len_byte;
         end else begin
            place_byte = 8'h00;
         end
      end
   end

   assign block_full = place && (pos_ff == sha1md_pkg::LAST_SLOT);

   // Bytes are packed big-endian; the fourth byte of a word writes the
   // whole word into the block memory.
   always_comb begin
      pos_in  = place ? pos_ff + 6'd1 : pos_ff;
      word_in = word_ff;
      if (place) begin
         case (pos_ff[1:0])
            2'd0:    word_in = {place_byte, 16'h0000};
            2'd1:    word_in = {word_ff[23:16], place_byte, 8'h00};
            2'd2:    word_in = {word_ff[23:8], place_byte};
            default: word_in = word_ff;
         endcase
      end
      ctrl.wr_en   = place && (pos_ff[1:0] == 2'd3);
      ctrl.wr_addr = pos_ff[5:2];
      ctrl.wr_data = {word_ff, place_byte};
      ctrl.start   = block_full;
      ctrl.restart = emit;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      mark_in      = mark_ff;
      len_in       = len_ff;
      fin_in       = fin_ff;
      emit         = 1'b0;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         sha1md_pkg::ST_IDLE: begin
            if (req_take) begin
               if (req_data.byte_valid) begin
                  count_in = count_ff + 64'd8;
               end
               fin_in = req_data.last;
               if (block_full) begin
                  state_in = sha1md_pkg::ST_COMP;
               end else if (req_data.last) begin
                  state_in = sha1md_pkg::ST_PAD;
               end
            end
         end
         sha1md_pkg::ST_PAD: begin
            mark_in = 1'b1;
            len_in  = len_ff || (pos_in == sha1md_pkg::LEN_SLOT);
            if (block_full) begin
               state_in = sha1md_pkg::ST_COMP;
            end
         end
         sha1md_pkg::ST_COMP: begin
            if (comp_done) begin
               if (fin_ff && len_ff) begin
                  state_in = sha1md_pkg::ST_EMIT;
               end else if (fin_ff) begin
                  state_in = sha1md_pkg::ST_PAD;
               end else begin
                  state_in = sha1md_pkg::ST_IDLE;
               end
            end
         end
         sha1md_pkg::ST_EMIT: begin
            if (rsp_free) begin
               emit         = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_in       = {chain[0], chain[1], chain[2], chain[3], chain[4]};
               count_in     = '0;
               mark_in      = 1'b0;
               len_in       = 1'b0;
               fin_in       = 1'b0;
               state_in     = sha1md_pkg::ST_IDLE;
            end
         end
         default: state_in = sha1md_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sha1md_pkg::ST_IDLE;
         pos_ff       <= '0;
         count_ff     <= '0;
         mark_ff      <= 1'b0;
         len_ff       <= 1'b0;
         fin_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= emit ? 6'd0 : pos_in;
         count_ff     <= count_in;
         mark_ff      <= mark_in;
         len_ff       <= len_in;
         fin_ff       <= fin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> hdl/sha1md_checker.sv
`timescale 1ns / 1ps

module sha1md_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input sha1md_pkg::req_type req_data,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input sha1md_pkg::rsp_type rsp_data
);

   // A digest held back by the receiver stays put.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled digest changed or vanished");

   // Reset leaves no digest pending.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("digest valid after reset");

   // A word that does not end the message never makes a digest appear.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_data.last && !rsp_valid |=> !rsp_valid)
      else $error("digest appeared without end of message");

   // The end of a message always takes the block busy, for padding or a compression.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.last |=> req_stall)
      else $error("input not held off after end of message");

   // A new digest is only loaded while input is held off.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("digest loaded while input was open");

endmodule

bind sha1_message_digest sha1md_checker u_checker (.*);
